### src/tbfe_pkg.sv
`default_nettype none
package tbfe_pkg;

  localparam int FRAME_BITS  = 13;
  localparam int CHAIN_LEN   = FRAME_BITS + 1;
  localparam int SLOW_LEVELS = 16;
  localparam int COUNT_W     = 5;

  localparam logic [SLOW_LEVELS-1:0] SLOW_ONE  = 16'h5555;
  localparam logic [SLOW_LEVELS-1:0] SLOW_ZERO = 16'h3333;

  localparam logic [COUNT_W-1:0] FAST_ONE_COUNT  = 5'd2;
  localparam logic [COUNT_W-1:0] FAST_ZERO_COUNT = 5'd3;
  localparam logic [COUNT_W-1:0] SLOW_COUNT      = 5'd16;
  localparam logic [COUNT_W-1:0] CLOSE_COUNT     = 5'd1;

  typedef struct packed {
    logic valid;
    logic frame_bit;
    logic last;
  } cell_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### src/tape_byte_frame_encoder_core.sv
`default_nettype none
// A byte's first result goes via the first chain cell and the output register.
// Throughput: fourteen result beats per byte, one per cycle unless the output stalls;
// set by the fourteen-cell frame chain, shifting one cell toward the output per beat.
// A new byte is taken in the cycle the last cell of the previous one leaves.
// Reset (rst, synchronous): chain and output empty, slow_mode 0, line level 0.
module tape_byte_frame_encoder_core
  import tbfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_wr_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // level_pattern[15:0], level_count[20:16], zero
  output logic             m_tlast    // frame_end
);

  logic                   slow_mode;
  logic                   byte_mode;
  logic                   line_level;
  logic [SLOW_LEVELS-1:0] out_pattern;
  logic [COUNT_W-1:0]     out_count;

  cell_t      chain [CHAIN_LEN];
  cell_t      load_value [CHAIN_LEN];
  cell_ctrl_t ctrl;
  logic       out_free;
  logic       take;

  assign out_free   = !m_tvalid || m_tready;
  assign ctrl.shift = out_free && chain[0].valid;
  assign s_tready   = !chain[1].valid && (!chain[0].valid || ctrl.shift);
  assign take       = s_tvalid && s_tready;
  assign ctrl.load  = take;

  always_comb begin
    for (int i = 0; i < CHAIN_LEN; i++) begin
      load_value[i].valid     = 1'b1;
      load_value[i].frame_bit = 1'b1;
      load_value[i].last      = 1'b0;
    end
    load_value[0].frame_bit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      load_value[i+1].frame_bit = s_tdata[i];
    end
    load_value[9].frame_bit          = ~(^s_tdata);
    load_value[CHAIN_LEN-1].last     = 1'b1;
  end

  for (genvar g = 0; g < CHAIN_LEN; g++) begin : g_cell
    cell_t neighbor;
    if (g == CHAIN_LEN - 1) begin : g_end
      assign neighbor = '0;
    end else begin : g_mid
      assign neighbor = chain[g+1];
    end
    tbfe_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .load_value (load_value[g]),
      .neighbor   (neighbor),
      .slot       (chain[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_mode  <= 1'b0;
      byte_mode  <= 1'b0;
      line_level <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slow_mode <= cfg_wr_data[0];
      end
      if (take) begin
        byte_mode <= slow_mode;
      end
      if (ctrl.shift) begin
        m_tvalid <= 1'b1;
        m_tlast  <= chain[0].last;
        if (chain[0].last) begin
          line_level <= ~line_level;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      if (chain[0].last) begin
        out_pattern <= {{(SLOW_LEVELS-1){1'b0}}, ~line_level};
        out_count   <= CLOSE_COUNT;
      end else if (byte_mode) begin
        out_pattern <= (chain[0].frame_bit ? SLOW_ONE : SLOW_ZERO)
                       ^ {SLOW_LEVELS{line_level}};
        out_count   <= SLOW_COUNT;
      end else if (chain[0].frame_bit) begin
        out_pattern <= {{(SLOW_LEVELS-2){1'b0}}, line_level, ~line_level};
        out_count   <= FAST_ONE_COUNT;
      end else begin
        out_pattern <= {{(SLOW_LEVELS-3){1'b0}}, line_level, line_level, ~line_level};
        out_count   <= FAST_ZERO_COUNT;
      end
    end
  end

  assign m_tdata = {3'b000, out_count, out_pattern};

endmodule
`default_nettype wire

### src/tbfe_cell.sv
`default_nettype none
module tbfe_cell
  import tbfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire cell_t      load_value,
  input  wire cell_t      neighbor,
  output cell_t           slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid     <= 1'b0;
      slot.frame_bit <= 1'b0;
      slot.last      <= 1'b0;
    end else if (ctrl.load) begin
      slot <= load_value;
    end else if (ctrl.shift) begin
      slot <= neighbor;
    end
  end

endmodule
`default_nettype wire
